@@ rtl/bdpe_pkg.sv @@
// shared types and constants of the button debounce press events unit
// depends on nothing; every module of the block imports it
package bdpe_pkg;

  localparam int unsigned CntW   = 17;
  localparam int unsigned LimitW = 16;
  localparam int unsigned IdxW   = 2;

  localparam logic [CntW-1:0] CntMax = {CntW{1'b1}};

  // register indexes of the configuration port
  localparam logic [IdxW-1:0] RegActiveLow     = 2'd0;
  localparam logic [IdxW-1:0] RegDebounceTicks = 2'd1;
  localparam logic [IdxW-1:0] RegHoldTicks     = 2'd2;

  // register reset values
  localparam logic              ActiveLowRst     = 1'b1;
  localparam logic [LimitW-1:0] DebounceTicksRst = 16'd50;
  localparam logic [LimitW-1:0] HoldTicksRst     = 16'd1000;

  typedef struct packed {
    logic              active_low;
    logic [LimitW-1:0] debounce_ticks;
    logic [LimitW-1:0] hold_ticks;
  } cfg_t;

  typedef struct packed {
    logic clicked;
    logic held;
    logic released;
    logic long_press;
  } res_t;

  function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] v);
    return (v == CntMax) ? CntMax : v + 1'b1;
  endfunction

endpackage

@@ rtl/bdpe_cfg_regs.sv @@
// configuration registers: polarity, debounce limit, hold limit
// depends on bdpe_pkg
module bdpe_cfg_regs
  import bdpe_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [IdxW-1:0]   cfg_index_i,
  input  logic [LimitW-1:0] cfg_wdata_i,
  output cfg_t              cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.active_low     <= ActiveLowRst;
      cfg_q.debounce_ticks <= DebounceTicksRst;
      cfg_q.hold_ticks     <= HoldTicksRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegActiveLow:     cfg_q.active_low     <= cfg_wdata_i[0];
        RegDebounceTicks: cfg_q.debounce_ticks <= cfg_wdata_i;
        RegHoldTicks:     cfg_q.hold_ticks     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/bdpe_in_stage.sv @@
// input register: holds one tick sample until the core takes it
// depends on bdpe_pkg (no symbols used beyond the import convention)
module bdpe_in_stage
  import bdpe_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  logic pin_level_i,
  input  logic advance_i,
  output logic valid_o,
  output logic pin_level_o
);

  logic valid_q, valid_d;
  logic pin_q;

  // free slot when empty or draining this cycle
  assign in_stall_o = valid_q && !advance_i;

  always_comb begin
    valid_d = valid_q;
    if (advance_i)                 valid_d = 1'b0;
    if (in_valid_i && !in_stall_o) valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      pin_q <= pin_level_i;
    end
  end

  assign valid_o     = valid_q;
  assign pin_level_o = pin_q;

endmodule

@@ rtl/bdpe_core.sv @@
// debounce state and per-tick result logic, updated once per advanced beat
// depends on bdpe_pkg
module bdpe_core
  import bdpe_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic advance_i,
  input  logic pin_level_i,
  output res_t res_o
);

  logic            prev_raw_q, prev_raw_d;
  logic            stable_q, stable_d;
  logic [CntW-1:0] settle_q, settle_d;
  logic [CntW-1:0] press_q, press_d;
  logic            pressed_q, pressed_d;
  logic            active_lvl;
  logic            accept_chg;

  assign active_lvl = ~cfg_i.active_low;

  always_comb begin
    res_o      = '0;
    prev_raw_d = pin_level_i;
    settle_d   = (pin_level_i != prev_raw_q) ? '0 : sat_inc(settle_q);
    stable_d   = stable_q;
    press_d    = press_q;
    pressed_d  = pressed_q;
    accept_chg = (settle_d > {1'b0, cfg_i.debounce_ticks}) && (pin_level_i != stable_q);
    if (accept_chg) begin
      stable_d = pin_level_i;
      if (pin_level_i == active_lvl) begin
        press_d       = '0;
        pressed_d     = 1'b1;
        res_o.clicked = 1'b1;
      end else begin
        res_o.released = pressed_q;
        pressed_d      = 1'b0;
      end
    end
    if (pressed_d && !res_o.clicked) press_d = sat_inc(press_d);
    res_o.held       = (stable_d == active_lvl);
    res_o.long_press = pressed_d && (press_d >= {1'b0, cfg_i.hold_ticks});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_raw_q <= ActiveLowRst;
      stable_q   <= ActiveLowRst;
      settle_q   <= '0;
      press_q    <= '0;
      pressed_q  <= 1'b0;
    end else if (advance_i) begin
      prev_raw_q <= prev_raw_d;
      stable_q   <= stable_d;
      settle_q   <= settle_d;
      press_q    <= press_d;
      pressed_q  <= pressed_d;
    end
  end

endmodule

@@ rtl/bdpe_out_stage.sv @@
// result register: holds one result beat until the receiver takes it
// depends on bdpe_pkg
module bdpe_out_stage
  import bdpe_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic load_i,
  input  res_t res_i,
  input  logic out_stall_i,
  output logic out_valid_o,
  output logic free_o,
  output res_t res_o
);

  logic valid_q;
  res_t res_q;

  assign free_o = !valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

@@ rtl/button_debounce_press_events_unit.sv @@
// top level of the button debounce press events unit
// depends on bdpe_pkg, bdpe_cfg_regs, bdpe_in_stage, bdpe_core, bdpe_out_stage
//
// usage
//   one input beat is one millisecond tick carrying the raw pin level
//   every input beat gives exactly one result beat: clicked, held,
//   released and long_press
//   both channels are valid/stall; a beat moves when valid is high and
//   stall is low at a rising edge
// timing
//   a tick is registered on entry, then the debounce state is updated by
//   a single pass of counters and compares into the result register
//   throughput: one tick per cycle, sustained with no stall
// stall behaviour
//   while the receiver stalls the result register holds; the input
//   register still takes one more tick, then input stall rises
// reset
//   rst_ni clears both pipeline slots, the counters and the press flag;
//   raw and stable level start at the inactive level of the reset polarity
//   (pull-up button), and the registers take their reset values
// configuration
//   write while idle; cfg_index_i selects polarity, debounce or hold limit
module button_debounce_press_events_unit
  import bdpe_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration write port
  input  logic              cfg_we_i,
  input  logic [IdxW-1:0]   cfg_index_i,
  input  logic [LimitW-1:0] cfg_wdata_i,
  // tick input channel
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              pin_level_i,
  // result channel
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              clicked_o,
  output logic              held_o,
  output logic              released_o,
  output logic              long_press_o
);

  cfg_t cfg;
  res_t core_res;
  res_t out_res;
  logic s1_valid;
  logic s1_pin;
  logic out_free;
  logic advance;

  // a registered tick goes through the core when the result slot frees
  assign advance = s1_valid && out_free;

  bdpe_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  bdpe_in_stage u_in (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .pin_level_i (pin_level_i),
    .advance_i   (advance),
    .valid_o     (s1_valid),
    .pin_level_o (s1_pin)
  );

  bdpe_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .advance_i   (advance),
    .pin_level_i (s1_pin),
    .res_o       (core_res)
  );

  bdpe_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance),
    .res_i       (core_res),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .free_o      (out_free),
    .res_o       (out_res)
  );

  assign clicked_o    = out_res.clicked;
  assign held_o       = out_res.held;
  assign released_o   = out_res.released;
  assign long_press_o = out_res.long_press;

endmodule

@@ verif/bdpe_event_checker.sv @@
// result checker for the button debounce press events unit: follows the config
// writes and tick beats, predicts clicked/held/released/long_press, compares them
// depends on bdpe_pkg for the register indexes, widths and reset values
module bdpe_event_checker
  import bdpe_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [IdxW-1:0]   cfg_index_i,
  input  logic [LimitW-1:0] cfg_wdata_i,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  logic              pin_level_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  logic              clicked_i,
  input  logic              held_i,
  input  logic              released_i,
  input  logic              long_press_i,
  output int                mismatches_o,
  output int                pending_o,
  output int                checked_o,
  output int                clicks_o,
  output int                releases_o,
  output int                long_ticks_o
);

  cfg_t            settings;
  logic            last_pin;
  logic            debounced;
  logic [CntW-1:0] settle_cnt;
  logic [CntW-1:0] press_cnt;
  logic            pressing;

  res_t expected_events[$];
  res_t next_event;
  res_t want;
  res_t got;
  int   mismatches;
  int   checked;
  int   clicks;
  int   releases;
  int   long_ticks;

  assign mismatches_o = mismatches;
  assign pending_o    = expected_events.size();
  assign checked_o    = checked;
  assign clicks_o     = clicks;
  assign releases_o   = releases;
  assign long_ticks_o = long_ticks;

  function automatic logic [CntW-1:0] count_up(input logic [CntW-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  task automatic advance_debounce(input logic pin, output res_t r);
    logic act;
    logic took_press;
    act        = ~settings.active_low;
    took_press = 1'b0;
    r          = '0;
    if (pin != last_pin) settle_cnt = '0;
    else settle_cnt = count_up(settle_cnt);
    if (settle_cnt > {1'b0, settings.debounce_ticks} && pin != debounced) begin
      debounced = pin;
      if (debounced == act) begin
        press_cnt  = '0;
        pressing   = 1'b1;
        r.clicked  = 1'b1;
        took_press = 1'b1;
      end else begin
        r.released = pressing;
        pressing   = 1'b0;
      end
    end
    if (pressing && !took_press) press_cnt = count_up(press_cnt);
    last_pin     = pin;
    r.held       = (debounced == act);
    r.long_press = pressing && (press_cnt >= {1'b0, settings.hold_ticks});
  endtask

  function automatic void check_field(input string name, input logic exp_v, input logic act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0b, got %0b", name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  initial begin
    mismatches = 0;
    checked    = 0;
    clicks     = 0;
    releases   = 0;
    long_ticks = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settings.active_low     = ActiveLowRst;
      settings.debounce_ticks = DebounceTicksRst;
      settings.hold_ticks     = HoldTicksRst;
      // the inactive level of a pull-up button is high
      last_pin   = ActiveLowRst;
      debounced  = ActiveLowRst;
      settle_cnt = '0;
      press_cnt  = '0;
      pressing   = 1'b0;
      expected_events.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          RegActiveLow:     settings.active_low     = cfg_wdata_i[0];
          RegDebounceTicks: settings.debounce_ticks = cfg_wdata_i;
          RegHoldTicks:     settings.hold_ticks     = cfg_wdata_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        advance_debounce(pin_level_i, next_event);
        expected_events.push_back(next_event);
      end
      if (out_valid_i && !out_stall_i) begin
        got = '{clicked: clicked_i, held: held_i, released: released_i,
                long_press: long_press_i};
        if (expected_events.size() == 0) begin
          $error("result beat with no tick outstanding");
          mismatches++;
        end else begin
          want = expected_events.pop_front();
          check_field("clicked", want.clicked, got.clicked);
          check_field("held", want.held, got.held);
          check_field("released", want.released, got.released);
          check_field("long_press", want.long_press, got.long_press);
          checked++;
          clicks     += want.clicked;
          releases   += want.released;
          long_ticks += want.long_press;
        end
      end
    end
  end

endmodule

@@ verif/button_debounce_press_events_unit_tb.sv @@
// testbench top for the button debounce press events unit: clock, reset,
// tick stimulus, register writes, result stall pattern and verdict
// depends on bdpe_pkg, button_debounce_press_events_unit and bdpe_event_checker
module button_debounce_press_events_unit_tb;
  import bdpe_pkg::*;

  // index with no register behind it, written to see it ignored
  localparam logic [IdxW-1:0] RegUnused = 2'd3;
  // cycle cap for a run of about 2k ticks at the slowest legal pace
  localparam int CycleLimit = 200_000;

  logic              clk_i        = 1'b0;
  logic              rst_ni       = 1'b0;
  logic              cfg_we_i     = 1'b0;
  logic [IdxW-1:0]   cfg_index_i  = RegActiveLow;
  logic [LimitW-1:0] cfg_wdata_i  = '0;
  logic              in_valid_i   = 1'b0;
  logic              pin_level_i  = 1'b1;
  logic              out_stall_i  = 1'b0;
  logic              in_stall_o;
  logic              out_valid_o;
  logic              clicked_o;
  logic              held_o;
  logic              released_o;
  logic              long_press_o;

  int mismatches;
  int pending;
  int checked;
  int clicks;
  int releases;
  int long_ticks;

  int          cycle_cnt   = 0;
  int          settings_cnt = 1;
  bit          gappy       = 1'b1;
  int unsigned burst_left  = 0;
  int unsigned cur_debounce = DebounceTicksRst;
  int unsigned cur_hold     = HoldTicksRst;

  // receiver stall pattern state
  int unsigned stall_mode  = 0;
  int unsigned stall_phase = 0;
  int unsigned stall_run   = 0;
  logic        stall_want;

  button_debounce_press_events_unit uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .pin_level_i  (pin_level_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .clicked_o    (clicked_o),
    .held_o       (held_o),
    .released_o   (released_o),
    .long_press_o (long_press_o)
  );

  bdpe_event_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .pin_level_i  (pin_level_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .clicked_i    (clicked_o),
    .held_i       (held_o),
    .released_i   (released_o),
    .long_press_i (long_press_o),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .checked_o    (checked),
    .clicks_o     (clicks),
    .releases_o   (releases),
    .long_ticks_o (long_ticks)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // watchdog: a hung handshake ends the run as a failure
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("button_debounce_press_events_unit_tb: done, errors");
      $finish;
    end
  end

  // receiver stall: switches at random between no stall, light random,
  // a periodic pattern and heavy random; long stall runs are broken up
  always @(negedge clk_i) begin
    if (stall_phase == 0) begin
      stall_mode  = $urandom_range(0, 3);
      stall_phase = $urandom_range(16, 96);
    end else begin
      stall_phase = stall_phase - 1;
    end
    case (stall_mode)
      0:       stall_want = 1'b0;
      1:       stall_want = ($urandom_range(0, 3) == 0);
      2:       stall_want = (stall_phase % 3 == 0);
      default: stall_want = 1'($urandom_range(0, 1));
    endcase
    if (stall_run >= 4) stall_want = 1'b0;
    stall_run = stall_want ? stall_run + 1 : 0;
    out_stall_i <= stall_want;
  end

  // one tick beat; entered and left at a falling edge. valid stays high
  // into the next beat unless the burst has run out and a gap is taken
  task automatic send_tick(input logic pin);
    in_valid_i  <= 1'b1;
    pin_level_i <= pin;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
    if (gappy) begin
      if (burst_left == 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk_i);
        burst_left = $urandom_range(1, 40);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic send_run(input logic pin, input int unsigned n);
    repeat (n) send_tick(pin);
  endtask

  // hold off until every tick in flight has produced its result beat
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // writes every register once, upper data bits of the polarity write
  // carry noise, and the spare index is poked last
  task automatic set_config(input logic act_low, input logic [LimitW-1:0] deb,
                            input logic [LimitW-1:0] hold);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= RegActiveLow;
    cfg_wdata_i <= {15'($urandom), act_low};
    @(negedge clk_i);
    cfg_index_i <= RegDebounceTicks;
    cfg_wdata_i <= deb;
    @(negedge clk_i);
    cfg_index_i <= RegHoldTicks;
    cfg_wdata_i <= hold;
    @(negedge clk_i);
    cfg_index_i <= RegUnused;
    cfg_wdata_i <= 16'($urandom);
    @(negedge clk_i);
    cfg_we_i     <= 1'b0;
    cur_debounce = deb;
    cur_hold     = hold;
    settings_cnt++;
  endtask

  // mostly level runs long enough to be accepted, often to reach long press,
  // mixed with bounce shorter than the debounce window and raw noise
  task automatic random_segment(input int unsigned target);
    int unsigned sent;
    int unsigned kind;
    int unsigned n;
    logic        lv;
    sent = 0;
    lv   = 1'($urandom_range(0, 1));
    while (sent < target) begin
      kind = $urandom_range(0, 9);
      if (kind < 6) begin
        n = cur_debounce + 2 + $urandom_range(0, cur_hold + 8);
        send_run(lv, n);
      end else if (kind < 9) begin
        n = $urandom_range(1, cur_debounce + 1);
        send_run(lv, n);
      end else begin
        n = $urandom_range(1, 5);
        repeat (n) send_tick(1'($urandom));
      end
      sent += n;
      lv = ~lv;
    end
  endtask

  initial begin
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset settings: pull-up button, 50 tick debounce, 1000 tick hold;
    // some bounce, a press, long press, then a release
    send_tick(1'b0);
    send_tick(1'b1);
    send_run(1'b0, 2);
    send_tick(1'b1);
    send_run(1'b0, 55);
    send_run(1'b0, 1005);
    send_run(1'b1, 55);
    drain();

    // active high, no debounce, zero hold: flipping polarity makes the
    // idle-high pin count as held at once, the drop to low is a release
    // with no press behind it, and long press shows on the click tick
    set_config(1'b0, '0, '0);
    send_run(1'b1, 2);
    send_run(1'b0, 3);
    send_run(1'b1, 3);
    send_run(1'b0, 3);
    send_run(1'b1, 3);
    drain();

    // widest debounce and hold, back to back; the press flag left over
    // from above keeps counting while the low level never settles
    gappy = 1'b0;
    set_config(1'b1, 16'hFFFF, 16'hFFFF);
    send_run(1'b0, 40);
    drain();
    // debounce window shut: the settled low is a press at once, then a release
    set_config(1'b1, '0, 16'hFFFF);
    send_run(1'b0, 3);
    send_run(1'b1, 3);
    drain();

    // random settings, each segment starting from an idle block
    gappy = 1'b1;
    repeat (2) begin
      set_config(1'($urandom_range(0, 1)),
                 16'(($urandom_range(0, 4) == 0) ? $urandom_range(7, 30)
                                                  : $urandom_range(0, 6)),
                 16'($urandom_range(0, 25)));
      random_segment(400);
      drain();
    end

    $display("checked %0d tick beats under %0d register settings", checked, settings_cnt);
    $display("seen %0d clicks, %0d releases and %0d long-press ticks",
             clicks, releases, long_ticks);
    if (mismatches == 0 && pending == 0) begin
      $display("button_debounce_press_events_unit_tb: done, clean");
    end else begin
      $display("button_debounce_press_events_unit_tb: done, errors");
    end
    $finish;
  end

endmodule

@@ button_debounce_press_events_unit.f @@
rtl/bdpe_pkg.sv
rtl/bdpe_cfg_regs.sv
rtl/bdpe_in_stage.sv
rtl/bdpe_core.sv
rtl/bdpe_out_stage.sv
rtl/button_debounce_press_events_unit.sv
verif/bdpe_event_checker.sv
verif/button_debounce_press_events_unit_tb.sv
